@@ hdl/tta_pkg.sv @@
// Shared constants, register indexes and control structs for the touch tap averager.
// Used by every module of the block; depends on nothing.
package tta_pkg;

	// Default averaging depth, screen geometry, raw sample and tap widths
	localparam int SAMPLE_LIMIT  = 5;
	localparam int SCREEN_WIDTH  = 480;
	localparam int SCREEN_HEIGHT = 320;
	localparam int RAW_BITS      = 12;
	localparam int TAP_W         = 12;

	// Stream payload widths
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	// Configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX      = 3'd4;

	localparam logic signed [CFG_W-1:0] RST_MIN = 16'sd0;
	localparam logic signed [CFG_W-1:0] RST_MAX = 16'sd4095;

	// Calibration arithmetic widths
	localparam int DIFF_W = 18;              // average minus edge, signed
	localparam int SIZE_W = 14;              // screen size as a signed operand
	localparam int PROD_W = DIFF_W + SIZE_W; // signed product
	localparam int NUM_W  = 29;              // dividend magnitude
	localparam int SPAN_W = 17;              // edge span, signed; also divisor width

	// Controller to datapath commands
	typedef struct packed {
		logic take;       // input transfer this cycle
		logic start_avg;  // start the averaging divide
		logic latch_avg;  // store the averages
		logic load_mul;   // form the scaled offsets and spans
		logic start_cal;  // start the calibration divide
		logic latch_cal;  // store the clamped screen coordinates
		logic load_out;   // move the tap into the output register
	} tta_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic release_hit; // offered item is a pen release after a press
		logic div_done;    // both divider lanes finished
		logic cal_enable;  // calibration switched on
		logic out_busy;    // output register holds a tap not yet taken
	} tta_sts_t;

endpackage

@@ hdl/touch_tap_averager_calibrator.sv @@
// Top level of the touch tap averager and calibrator.
// Depends on tta_pkg, tta_ctrl and tta_dp (which holds two tta_div lanes).
//
//  channel  | direction | content
//  s_*      | in        | one scan tick: pen level and raw X/Y samples
//  m_*      | out       | one tap per pen release: X and Y coordinates
//  cfg_*    | in        | write-only calibration registers
//
// A pen-down tick or an idle pen-up tick leaves the block ready for the next tick. After a
// release tick the block holds s_tready low while the bit-serial divider runs for
// the averages and, with calibration on, again for the calibrated coordinates.
// The tap appears as s_tready rises; if the previous tap is still waiting, the
// release stalls until it goes.
// Reset clears the state machine, accumulators and calibration registers to defaults.
module touch_tap_averager_calibrator #(
	parameter int SAMPLE_LIMIT = tta_pkg::SAMPLE_LIMIT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tta_pkg::IN_TDATA_W-1:0]    s_tdata,   // pen_down, raw_x, raw_y
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tta_pkg::OUT_TDATA_W-1:0]   m_tdata,   // tap_x, tap_y
	input  logic                              cfg_we,
	input  logic [tta_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [tta_pkg::CFG_W-1:0]         cfg_wdata
);

	tta_pkg::tta_cmd_t cmd;
	tta_pkg::tta_sts_t sts;

	tta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tta_dp #(
		.SAMPLE_LIMIT (SAMPLE_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef SYNTHESIS
	// A release transfer takes the block out of the accepting state
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_avg |=> !s_tready)
		else $error("input still ready after a release transfer");

	// Divider completion is only seen while a release is worked on
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> !s_tready)
		else $error("divider finished while idle");

	// A loaded tap is presented on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("loaded tap not presented");

	// Never overwrite a tap that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(m_tvalid && !m_tready))
		else $error("tap overwritten before transfer");
`endif

endmodule

@@ hdl/tta_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tta_pkg for default widths; used by tta_dp for both the averages and the calibration.
module tta_div #(
	parameter int NUM_W = tta_pkg::NUM_W,
	parameter int DEN_W = tta_pkg::SPAN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   trial;

	// Shift in the next dividend bit and try to subtract
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (trial[DEN_W]) begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/tta_dp.sv @@
// Datapath: config registers, sample accumulators, scaling, two divider lanes, output register.
// Depends on tta_pkg and tta_div; driven by commands from tta_ctrl.
module tta_dp #(
	parameter int SAMPLE_LIMIT = tta_pkg::SAMPLE_LIMIT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tta_pkg::tta_cmd_t                   cmd,
	output tta_pkg::tta_sts_t                   sts,
	input  logic                                cfg_we,
	input  logic [tta_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [tta_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic [tta_pkg::IN_TDATA_W-1:0]      in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tta_pkg::OUT_TDATA_W-1:0]     out_data
);

	localparam int RAW_W  = tta_pkg::RAW_BITS;
	localparam int TAP_W  = tta_pkg::TAP_W;
	localparam int CNT_W  = $clog2(SAMPLE_LIMIT + 1);
	localparam int SUM_W  = RAW_W + $clog2(SAMPLE_LIMIT);
	localparam int DIFF_W = tta_pkg::DIFF_W;
	localparam int SIZE_W = tta_pkg::SIZE_W;
	localparam int PROD_W = tta_pkg::PROD_W;
	localparam int NUM_W  = tta_pkg::NUM_W;
	localparam int SPAN_W = tta_pkg::SPAN_W;
	localparam int CFG_W  = tta_pkg::CFG_W;

	localparam logic signed [SIZE_W-1:0] SIZE_X = SIZE_W'(tta_pkg::SCREEN_WIDTH);
	localparam logic signed [SIZE_W-1:0] SIZE_Y = SIZE_W'(tta_pkg::SCREEN_HEIGHT);
	localparam logic [NUM_W-1:0] LAST_X = NUM_W'(tta_pkg::SCREEN_WIDTH - 1);
	localparam logic [NUM_W-1:0] LAST_Y = NUM_W'(tta_pkg::SCREEN_HEIGHT - 1);

	// Configuration registers
	logic                    cal_en_q;
	logic signed [CFG_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

	// Accumulators
	logic             was_pressed_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_x_q, sum_y_q;

	// Working registers
	logic [TAP_W-1:0]         res_x_q, res_y_q;
	logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
	logic signed [SPAN_W-1:0] span_x_q, span_y_q;
	logic                     out_valid_q;
	logic [TAP_W-1:0]         out_x_q, out_y_q;

	// Input fields
	logic             pen;
	logic [RAW_W-1:0] raw_x, raw_y;

	assign pen   = in_data[0];
	assign raw_x = in_data[RAW_W:1];
	assign raw_y = in_data[2*RAW_W:RAW_W+1];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_en_q <= 1'b0;
			x_min_q  <= tta_pkg::RST_MIN;
			x_max_q  <= tta_pkg::RST_MAX;
			y_min_q  <= tta_pkg::RST_MIN;
			y_max_q  <= tta_pkg::RST_MAX;
		end else if (cfg_we) begin
			case (cfg_addr)
				tta_pkg::REG_CAL_ENABLE: cal_en_q <= cfg_wdata[0];
				tta_pkg::REG_X_MIN:      x_min_q  <= cfg_wdata;
				tta_pkg::REG_X_MAX:      x_max_q  <= cfg_wdata;
				tta_pkg::REG_Y_MIN:      y_min_q  <= cfg_wdata;
				tta_pkg::REG_Y_MAX:      y_max_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Accumulate samples while pressed; clear on press and on release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q <= 1'b0;
			cnt_q         <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
		end else if (cmd.take) begin
			if (pen) begin
				if (!was_pressed_q) begin
					was_pressed_q <= 1'b1;
					cnt_q         <= CNT_W'(1);
					sum_x_q       <= SUM_W'(raw_x);
					sum_y_q       <= SUM_W'(raw_y);
				end else if (cnt_q < CNT_W'(SAMPLE_LIMIT)) begin
					cnt_q   <= cnt_q + 1'b1;
					sum_x_q <= sum_x_q + SUM_W'(raw_x);
					sum_y_q <= sum_y_q + SUM_W'(raw_y);
				end
			end else if (was_pressed_q) begin
				was_pressed_q <= 1'b0;
				cnt_q         <= '0;
				sum_x_q       <= '0;
				sum_y_q       <= '0;
			end
		end
	end

	// Offsets from the left or top edge
	logic signed [DIFF_W-1:0] diff_x, diff_y;

	assign diff_x = DIFF_W'($signed({1'b0, res_x_q})) - DIFF_W'(x_min_q);
	assign diff_y = DIFF_W'($signed({1'b0, res_y_q})) - DIFF_W'(y_min_q);

	// Scale offsets by screen size and form the spans
	always_ff @(posedge clk) begin
		if (cmd.load_mul) begin
			prod_x_q <= diff_x * SIZE_X;
			prod_y_q <= diff_y * SIZE_Y;
			span_x_q <= SPAN_W'(x_max_q) - SPAN_W'(x_min_q);
			span_y_q <= SPAN_W'(y_max_q) - SPAN_W'(y_min_q);
		end
	end

	// Magnitudes for the unsigned divider
	logic                     prod_x_neg, prod_y_neg, span_x_neg, span_y_neg;
	logic signed [PROD_W-1:0] prod_x_abs, prod_y_abs;
	logic signed [SPAN_W-1:0] span_x_abs, span_y_abs;

	assign prod_x_neg = prod_x_q[PROD_W-1];
	assign prod_y_neg = prod_y_q[PROD_W-1];
	assign span_x_neg = span_x_q[SPAN_W-1];
	assign span_y_neg = span_y_q[SPAN_W-1];
	assign prod_x_abs = prod_x_neg ? -prod_x_q : prod_x_q;
	assign prod_y_abs = prod_y_neg ? -prod_y_q : prod_y_q;
	assign span_x_abs = span_x_neg ? -span_x_q : span_x_q;
	assign span_y_abs = span_y_neg ? -span_y_q : span_y_q;

	// Divider operands: sums over count, or scaled offsets over spans
	logic              div_start, done_x, done_y;
	logic [NUM_W-1:0]  num_x, num_y, quo_x, quo_y;
	logic [SPAN_W-1:0] den_x, den_y;

	assign div_start = cmd.start_avg | cmd.start_cal;
	assign num_x = cmd.start_cal ? prod_x_abs[NUM_W-1:0] : NUM_W'(sum_x_q);
	assign num_y = cmd.start_cal ? prod_y_abs[NUM_W-1:0] : NUM_W'(sum_y_q);
	assign den_x = cmd.start_cal ? span_x_abs : SPAN_W'(cnt_q);
	assign den_y = cmd.start_cal ? span_y_abs : SPAN_W'(cnt_q);

	tta_div #(
		.NUM_W (NUM_W),
		.DEN_W (SPAN_W)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_x),
		.divisor  (den_x),
		.done     (done_x),
		.quotient (quo_x)
	);

	tta_div #(
		.NUM_W (NUM_W),
		.DEN_W (SPAN_W)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_y),
		.divisor  (den_y),
		.done     (done_y),
		.quotient (quo_y)
	);

	// Clamp calibrated coordinates: zero span or negative quotient gives 0
	logic [TAP_W-1:0] cal_x, cal_y;

	always_comb begin
		if (span_x_q == '0 || (prod_x_neg ^ span_x_neg)) begin
			cal_x = '0;
		end else if (quo_x > LAST_X) begin
			cal_x = LAST_X[TAP_W-1:0];
		end else begin
			cal_x = quo_x[TAP_W-1:0];
		end
		if (span_y_q == '0 || (prod_y_neg ^ span_y_neg)) begin
			cal_y = '0;
		end else if (quo_y > LAST_Y) begin
			cal_y = LAST_Y[TAP_W-1:0];
		end else begin
			cal_y = quo_y[TAP_W-1:0];
		end
	end

	// Hold the averages, then the calibrated result
	always_ff @(posedge clk) begin
		if (cmd.latch_avg) begin
			res_x_q <= quo_x[TAP_W-1:0];
			res_y_q <= quo_y[TAP_W-1:0];
		end else if (cmd.latch_cal) begin
			res_x_q <= cal_x;
			res_y_q <= cal_y;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_x_q <= res_x_q;
			out_y_q <= res_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {out_y_q, out_x_q};

	// Status back to the controller
	assign sts.release_hit = !pen && was_pressed_q;
	assign sts.div_done    = done_x & done_y;
	assign sts.cal_enable  = cal_en_q;
	assign sts.out_busy    = out_valid_q && !out_ready;

endmodule

@@ hdl/tta_ctrl.sv @@
// Controller state machine: sequences averaging, scaling, calibration and output load.
// Depends on tta_pkg; steers tta_dp through command and status structs.
module tta_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tta_pkg::tta_sts_t sts,
	output tta_pkg::tta_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_AVG    = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_CAL_GO = 3'd3;
	localparam logic [2:0] S_CAL    = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q, state_nxt;

	// Next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid && sts.release_hit) begin
					cmd.start_avg = 1'b1;
					state_nxt     = S_AVG;
				end
			end
			S_AVG: begin
				if (sts.div_done) begin
					cmd.latch_avg = 1'b1;
					state_nxt     = sts.cal_enable ? S_MUL : S_OUT;
				end
			end
			S_MUL: begin
				cmd.load_mul = 1'b1;
				state_nxt    = S_CAL_GO;
			end
			S_CAL_GO: begin
				cmd.start_cal = 1'b1;
				state_nxt     = S_CAL;
			end
			S_CAL: begin
				if (sts.div_done) begin
					cmd.latch_cal = 1'b1;
					state_nxt     = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ tb/touch_tap_averager_calibrator_checker.sv @@
// Scoreboard for the touch tap averager: watches the scan, tap and register channels.
// Predicts each tap from the accepted ticks and compares it field by field.
// Depends on tta_pkg for widths, register indexes and screen geometry.
module touch_tap_averager_calibrator_checker
	import tta_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // pen_down, raw_x, raw_y
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // tap_x, tap_y
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata,
	output int                     errors,
	output int                     pending,
	output int                     taps_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [TAP_W-1:0] tap_y;
		logic [TAP_W-1:0] tap_x;
	} tap_t;

	// Shadow of the calibration registers
	logic                    cal_on;
	logic signed [CFG_W-1:0] x_left, x_right, y_top, y_bottom;

	// Shadow of the press accumulator
	logic        pen_held;
	logic [2:0]  samples;
	logic [14:0] acc_x, acc_y;

	tap_t expected_taps[$];

	// Map one averaged axis onto the screen, truncating and clamping
	function automatic logic [TAP_W-1:0] scale_axis(input logic [TAP_W-1:0] avg,
			input logic signed [CFG_W-1:0] lo, input logic signed [CFG_W-1:0] hi,
			input int size);
		longint span;
		longint c;
		span = longint'(hi) - longint'(lo);
		if (span == 0)
			return '0;
		c = (longint'(avg) - longint'(lo)) * longint'(size) / span;
		if (c < 0)
			c = 0;
		if (c > size - 1)
			c = size - 1;
		return c[TAP_W-1:0];
	endfunction

	// Fold one scan tick into the accumulator; return 1 with the tap on a release
	function automatic bit absorb_tick(input logic pen, input logic [RAW_BITS-1:0] rx,
			input logic [RAW_BITS-1:0] ry, output tap_t tap);
		logic [TAP_W-1:0] avg_x, avg_y;
		tap = '0;
		if (pen) begin
			if (!pen_held) begin
				samples  = '0;
				acc_x    = '0;
				acc_y    = '0;
				pen_held = 1'b1;
			end
			if (samples < SAMPLE_LIMIT) begin
				acc_x   = acc_x + rx;
				acc_y   = acc_y + ry;
				samples = samples + 1'b1;
			end
			return 1'b0;
		end
		if (!pen_held)
			return 1'b0;
		pen_held = 1'b0;
		if (samples != 0) begin
			avg_x = TAP_W'(acc_x / samples);
			avg_y = TAP_W'(acc_y / samples);
		end else begin
			avg_x = '0;
			avg_y = '0;
		end
		if (cal_on) begin
			tap.tap_x = scale_axis(avg_x, x_left, x_right, SCREEN_WIDTH);
			tap.tap_y = scale_axis(avg_y, y_top, y_bottom, SCREEN_HEIGHT);
		end else begin
			tap.tap_x = avg_x;
			tap.tap_y = avg_y;
		end
		samples = '0;
		acc_x   = '0;
		acc_y   = '0;
		return 1'b1;
	endfunction

	// Track register writes, compare taps, queue predictions
	always @(posedge clk or negedge arst_n) begin
		tap_t got, want, fresh;
		if (!arst_n) begin
			cal_on   = 1'b0;
			x_left   = RST_MIN;
			x_right  = RST_MAX;
			y_top    = RST_MIN;
			y_bottom = RST_MAX;
			pen_held = 1'b0;
			samples  = '0;
			acc_x    = '0;
			acc_y    = '0;
			expected_taps.delete();
			pending  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_CAL_ENABLE: cal_on   = cfg_wdata[0];
					REG_X_MIN:      x_left   = cfg_wdata;
					REG_X_MAX:      x_right  = cfg_wdata;
					REG_Y_MIN:      y_top    = cfg_wdata;
					REG_Y_MAX:      y_bottom = cfg_wdata;
					default: ;
				endcase
			end
			// compare a tap transfer against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = m_tdata[2*TAP_W-1:0];
				if (expected_taps.size() == 0) begin
					errors++;
					$display("%0t: tap with none expected, got x=%0d y=%0d",
						$time, got.tap_x, got.tap_y);
				end else begin
					want = expected_taps.pop_front();
					taps_checked++;
					if (got.tap_x !== want.tap_x) begin
						errors++;
						$display("%0t: tap_x mismatch, expected %0d, got %0d",
							$time, want.tap_x, got.tap_x);
					end
					if (got.tap_y !== want.tap_y) begin
						errors++;
						$display("%0t: tap_y mismatch, expected %0d, got %0d",
							$time, want.tap_y, got.tap_y);
					end
				end
			end
			// predict from a scan transfer
			if (s_tvalid && s_tready) begin
				if (absorb_tick(s_tdata[0], s_tdata[RAW_BITS:1],
						s_tdata[2*RAW_BITS:RAW_BITS+1], fresh))
					expected_taps.push_back(fresh);
			end
			pending = expected_taps.size();
		end
	end

endmodule

@@ tb/touch_tap_averager_calibrator_test.sv @@
// Top of the touch tap averager testbench: clock, reset, scan stimulus, tap sink, verdict.
// Depends on tta_pkg, the block itself and touch_tap_averager_calibrator_checker.
module touch_tap_averager_calibrator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tta_pkg::*;

	localparam int RANDOM_TICKS = 1900;
	localparam int PHASE_TICKS  = 160;
	localparam int SETTLE_WAIT  = 70;       // longer than a calibrated release
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 2000000;

	typedef enum {SET_RAW, SET_TYPICAL, SET_EXTREME, SET_ZERO_SPAN, SET_INVERTED,
		SET_RANDOM} setting_kind_e;
	typedef enum {SPREAD, CLUSTER, RAIL, STEADY} sample_style_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;    // pen_down, raw_x, raw_y
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // tap_x, tap_y
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = REG_CAL_ENABLE;
	logic [CFG_W-1:0]       cfg_wdata = '0;

	int errors, pending, taps_checked;
	int cycle_count = 0;
	int ticks_sent = 0;
	int settings_written = 0;
	bit calm = 1'b0;
	bit hold_request = 1'b0;

	touch_tap_averager_calibrator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	touch_tap_averager_calibrator_checker tap_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.pending     (pending),
		.taps_checked(taps_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("touch_tap_averager_calibrator_test failed");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [RAW_BITS-1:0] raw_sample(input sample_style_e style,
			input logic [RAW_BITS-1:0] base);
		int v;
		case (style)
			SPREAD: return RAW_BITS'($urandom);
			CLUSTER: begin
				v = int'(base) + int'($urandom_range(0, 32)) - 16;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
				return RAW_BITS'(v);
			end
			RAIL: return $urandom_range(0, 1) ? '1 : '0;
			default: return base;
		endcase
	endfunction

	// Tap sink: random stalls, plus one long hold-off on request
	initial begin
		int run, stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end
			m_tready <= 1'b1;
			run = $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Offer one scan tick and hold it until the transfer
	task automatic send_tick(input logic pen, input logic [RAW_BITS-1:0] rx,
			input logic [RAW_BITS-1:0] ry);
		int g;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-2*RAW_BITS-1){1'b0}}, ry, rx, pen};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Pause the scan side until every tap is out and the block is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic program_cal(input logic en, input logic signed [CFG_W-1:0] xl,
			input logic signed [CFG_W-1:0] xr, input logic signed [CFG_W-1:0] yt,
			input logic signed [CFG_W-1:0] yb);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_CAL_ENABLE;
		cfg_wdata <= {{(CFG_W-1){1'b0}}, en};
		@(posedge clk);
		cfg_addr  <= REG_X_MIN;
		cfg_wdata <= xl;
		@(posedge clk);
		cfg_addr  <= REG_X_MAX;
		cfg_wdata <= xr;
		@(posedge clk);
		cfg_addr  <= REG_Y_MIN;
		cfg_wdata <= yt;
		@(posedge clk);
		cfg_addr  <= REG_Y_MAX;
		cfg_wdata <= yb;
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings_written++;
	endtask

	task automatic program_setting(input setting_kind_e kind);
		logic signed [CFG_W-1:0] a, b, c, d;
		a = CFG_W'($urandom_range(0, 600));
		b = CFG_W'($urandom_range(3500, 4095));
		c = CFG_W'($urandom_range(0, 600));
		d = CFG_W'($urandom_range(3500, 4095));
		case (kind)
			SET_RAW:
				program_cal(1'b0, CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
					CFG_W'($urandom));
			SET_TYPICAL: program_cal(1'b1, a, b, c, d);
			SET_EXTREME:
				if ($urandom_range(0, 1))
					program_cal(1'b1, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
				else
					program_cal(1'b1, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
			SET_ZERO_SPAN:
				if ($urandom_range(0, 1))
					program_cal(1'b1, a, a, c, d);
				else
					program_cal(1'b1, a, b, d, d);
			SET_INVERTED: program_cal(1'b1, b, a, d, c);
			default:
				// narrow spans sometimes, to push the clamp hard
				if ($urandom_range(0, 2) == 0)
					program_cal(1'b1, b, b + 16'sd1, c, c + 16'sd2);
				else
					program_cal(1'b1, CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
						CFG_W'($urandom));
		endcase
	endtask

	// Press for n ticks with fixed samples, then release
	task automatic hold_tap(input int n, input logic [RAW_BITS-1:0] rx,
			input logic [RAW_BITS-1:0] ry);
		repeat (n) send_tick(1'b1, rx, ry);
		send_tick(1'b0, RAW_BITS'($urandom), RAW_BITS'($urandom));
	endtask

	// One random touch: optional idle noise, a press of random length, a release
	task automatic random_touch();
		int n, r;
		sample_style_e style;
		logic [RAW_BITS-1:0] bx, by;
		if ($urandom_range(0, 9) == 0)
			send_tick(1'b0, RAW_BITS'($urandom), RAW_BITS'($urandom));
		r = $urandom_range(0, 99);
		if (r < 15)
			n = 1;
		else if (r < 75)
			n = $urandom_range(2, 5);
		else if (r < 95)
			n = $urandom_range(6, 9);
		else
			n = $urandom_range(10, 20);
		style = sample_style_e'($urandom_range(0, 3));
		bx = RAW_BITS'($urandom);
		by = RAW_BITS'($urandom);
		repeat (n) send_tick(1'b1, raw_sample(style, bx), raw_sample(style, by));
		send_tick(1'b0, RAW_BITS'($urandom), RAW_BITS'($urandom));
	endtask

	initial begin
		int phase, random_start, phase_end;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: raw averages, idle release, rail samples, sample limit
		send_tick(1'b0, '1, '1);
		hold_tap(1, '1, '1);
		hold_tap(1, '0, '0);
		for (int i = 0; i < 7; i++)
			send_tick(1'b1, RAW_BITS'(i * 600), RAW_BITS'(4095 - i * 600));
		send_tick(1'b0, '0, '1);

		// Calibrated, both clamps
		settle();
		program_cal(1'b1, 16'sd100, 16'sd3995, 16'sd100, 16'sd3995);
		hold_tap(1, '0, '0);
		hold_tap(1, '1, '1);

		// Zero span on both axes
		settle();
		program_cal(1'b1, 16'sd2000, 16'sd2000, -16'sd32768, -16'sd32768);
		hold_tap(2, 12'd1234, 12'd3210);

		// Register extremes, one axis inverted
		settle();
		program_cal(1'b1, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
		hold_tap(1, '1, '0);

		// Registers change mid-press; the release must use the new ones
		send_tick(1'b1, 12'd2048, 12'd1024);
		settle();
		program_cal(1'b1, 16'sd4095, 16'sd0, 16'sd0, 16'sd320);
		send_tick(1'b0, '0, '0);

		// Random touches, a new register setting each phase
		random_start = ticks_sent;
		phase = 0;
		while (ticks_sent - random_start < RANDOM_TICKS) begin
			phase++;
			if (phase % 3 == 1) begin
				repeat ($urandom_range(1, 6))
					send_tick(1'b1, RAW_BITS'($urandom), RAW_BITS'($urandom));
				settle();
				program_setting(setting_kind_e'(phase % 6));
				send_tick(1'b0, RAW_BITS'($urandom), RAW_BITS'($urandom));
			end else begin
				settle();
				program_setting(setting_kind_e'(phase % 6));
			end
			calm = (phase % 4 == 3);
			if (phase == 2 || phase == 7)
				hold_request = 1'b1;
			phase_end = ticks_sent + PHASE_TICKS;
			while (ticks_sent < phase_end)
				random_touch();
		end

		// Drain and give the verdict
		settle();
		$display("Sent %0d scan ticks and compared %0d taps over %0d register settings,",
			ticks_sent, taps_checked, settings_written);
		$display("including raw, clamped, zero-span, inverted and mid-press changes.");
		if (errors == 0)
			$display("touch_tap_averager_calibrator_test passed");
		else
			$display("touch_tap_averager_calibrator_test failed");
		$finish;
	end

endmodule
